>>> hdl/sqmm_pkg.sv
// Shared types and constants for the square matrix multiply engine.
package sqmm_pkg;

  localparam int unsigned SUM_W      = 40;
  localparam int unsigned SIZE_W     = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned VALUE_W    = 16;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic [1:0] KIND_WR_A  = 2'd0;
  localparam logic [1:0] KIND_WR_B  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row_res;
    logic [IDX_W-1:0]        col_res;
    logic signed [SUM_W-1:0] product_sum;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic clr;
    logic prod_en;
    logic acc_en;
    logic a_ok;
    logic b_ok;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

endpackage

>>> hdl/sqmm_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module sqmm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sqmm_mac.sv
// Multiply-accumulate datapath: registered product, 40-bit wrapping accumulator.
module sqmm_mac #(
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                              clk,
  input  sqmm_pkg::mac_ctl_t                ctl,
  input  logic [ELEMENT_WIDTH-1:0]          a_data,
  input  logic [ELEMENT_WIDTH-1:0]          b_data,
  output logic signed [sqmm_pkg::SUM_W-1:0] acc
);

  localparam int unsigned PW = 2 * ELEMENT_WIDTH;
  localparam int unsigned XW = (PW > sqmm_pkg::SUM_W) ? PW : sqmm_pkg::SUM_W;

  logic signed [ELEMENT_WIDTH-1:0]   a_op;
  logic signed [ELEMENT_WIDTH-1:0]   b_op;
  logic signed [PW-1:0]              prod_r;
  logic signed [XW-1:0]              prod_ext;
  logic signed [sqmm_pkg::SUM_W-1:0] acc_r;

  // Elements outside the stored matrices count as zero.
  assign a_op     = ctl.a_ok ? $signed(a_data) : '0;
  assign b_op     = ctl.b_ok ? $signed(b_data) : '0;
  assign prod_ext = XW'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod_r <= a_op * b_op;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + prod_ext[sqmm_pkg::SUM_W-1:0];
    end
  end

  assign acc = acc_r;

endmodule

>>> hdl/square_matrix_multiply.sv
// Square matrix multiply engine: element loads into A and B, dot-product queries.
//
// A and B each live in a synchronous RAM of MAX_SIZE*MAX_SIZE elements of
// ELEMENT_WIDTH bits, with no clearing after reset: query only elements that
// were loaded. A load transfer (kind 0 for A, 1 for B) gives no result; writes
// with row or col at or beyond MAX_SIZE are dropped and kind 3 is ignored. A
// query (kind 2) reads one element pair per cycle from both RAMs and feeds a
// single multiply-accumulate unit, so in_ready stays low after the query
// transfer through size_in_use reads, the RAM read register, the product
// register and the final accumulate, and until the result has entered the
// output register; with size_in_use zero there are no reads. The result goes
// into an output register; load transfers are taken while it waits, and a
// finished query holds until the register is free. size_in_use above MAX_SIZE
// is treated as MAX_SIZE; zero gives a sum of zero. Write cfg_wr_en only while
// the block is idle.
module square_matrix_multiply #(
  parameter int unsigned MAX_SIZE      = 16,
  parameter int unsigned ELEMENT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sqmm_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sqmm_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [sqmm_pkg::SIZE_W-1:0]      cfg_wr_data
);

  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int unsigned NW    = $clog2(MAX_SIZE + 1);

  sqmm_pkg::state_t                 state_r, state_nxt;
  logic [sqmm_pkg::SIZE_W-1:0]      size_r;
  logic [NW-1:0]                    n_r;
  logic [KW-1:0]                    k_r, k_nxt;
  logic [sqmm_pkg::IDX_W-1:0]       row_r, col_r;
  logic                             row_ok_r, col_ok_r;
  logic                             rd_vld_r, rd_vld_nxt;
  logic                             prd_vld_r;
  logic                             out_valid_r, out_valid_nxt;
  sqmm_pkg::out_item_t              out_data_r;

  logic                             in_xfer;
  logic                             is_query;
  logic                             wr_ok;
  logic                             we_a, we_b;
  logic [AW-1:0]                    waddr;
  logic [ELEMENT_WIDTH+15:0]        value_wide;
  logic [ELEMENT_WIDTH-1:0]         wdata;
  logic [AW-1:0]                    raddr_a, raddr_b;
  logic [ELEMENT_WIDTH-1:0]         rdata_a, rdata_b;
  logic [NW-1:0]                    n_sat;
  logic                             last_k;
  logic                             pipe_empty;
  logic                             load_out;
  sqmm_pkg::mac_ctl_t               mac_ctl;
  logic signed [sqmm_pkg::SUM_W-1:0] acc;

  assign in_ready = (state_r == sqmm_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign is_query = (in_data.kind == sqmm_pkg::KIND_QUERY);

  // Load path
  assign wr_ok = (32'(in_data.row) < MAX_SIZE) && (32'(in_data.col) < MAX_SIZE);
  assign we_a  = in_xfer && wr_ok && (in_data.kind == sqmm_pkg::KIND_WR_A);
  assign we_b  = in_xfer && wr_ok && (in_data.kind == sqmm_pkg::KIND_WR_B);
  assign waddr = AW'(32'(in_data.row) * MAX_SIZE + 32'(in_data.col));
  assign value_wide = {{ELEMENT_WIDTH{1'b0}}, in_data.value};
  assign wdata      = value_wide[ELEMENT_WIDTH-1:0];

  // Query read path: row of A, column of B
  assign raddr_a = AW'(32'(row_r) * MAX_SIZE + 32'(k_r));
  assign raddr_b = AW'(32'(k_r) * MAX_SIZE + 32'(col_r));

  assign n_sat  = (32'(size_r) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_r);
  assign last_k = (32'(k_r) + 32'd1 == 32'(n_r));
  assign pipe_empty = !rd_vld_r && !prd_vld_r;
  assign load_out   = (state_r == sqmm_pkg::ST_DRAIN) && pipe_empty &&
                      (!out_valid_r || out_ready);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    rd_vld_nxt = 1'b0;
    unique case (state_r)
      sqmm_pkg::ST_IDLE: begin
        k_nxt = '0;
        if (in_xfer && is_query) begin
          state_nxt = (n_sat == '0) ? sqmm_pkg::ST_DRAIN : sqmm_pkg::ST_RUN;
        end
      end
      sqmm_pkg::ST_RUN: begin
        rd_vld_nxt = 1'b1;
        k_nxt      = k_r + 1'b1;
        if (last_k) begin
          state_nxt = sqmm_pkg::ST_DRAIN;
        end
      end
      sqmm_pkg::ST_DRAIN: begin
        if (load_out) begin
          state_nxt = sqmm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sqmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sqmm_pkg::ST_IDLE;
      size_r      <= sqmm_pkg::SIZE_RESET;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      prd_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      prd_vld_r   <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
    end
  end

  // Hold the query coordinates for the whole dot product.
  always_ff @(posedge clk) begin
    if (in_xfer && is_query) begin
      row_r    <= in_data.row;
      col_r    <= in_data.col;
      row_ok_r <= (32'(in_data.row) < MAX_SIZE);
      col_ok_r <= (32'(in_data.col) < MAX_SIZE);
      n_r      <= n_sat;
    end
    if (load_out) begin
      out_data_r.row_res     <= row_r;
      out_data_r.col_res     <= col_r;
      out_data_r.product_sum <= acc;
    end
  end

  assign mac_ctl.clr     = in_xfer && is_query;
  assign mac_ctl.prod_en = rd_vld_r;
  assign mac_ctl.acc_en  = prd_vld_r;
  assign mac_ctl.a_ok    = row_ok_r;
  assign mac_ctl.b_ok    = col_ok_r;

  sqmm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  sqmm_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  sqmm_mac #(
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a_data (rdata_a),
    .b_data (rdata_b),
    .acc    (acc)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/sqmm_chk.sv
// Port-level checker for the square matrix multiply engine, bound to the top level.
module sqmm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input sqmm_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input sqmm_pkg::out_item_t         out_data
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // No transfer produces a result in the very next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after an input transfer");

  // A query occupies the engine: input stalls right after it.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.kind == sqmm_pkg::KIND_QUERY) |=> !in_ready)
    else $error("input taken while a query is in progress");

endmodule

bind square_matrix_multiply sqmm_chk u_sqmm_chk (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the square matrix multiply engine.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_DIM = 16;
  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_OPS = 222;
  localparam int IDX_BITS = sqmm_pkg::IDX_W;
  localparam int VAL_BITS = sqmm_pkg::VALUE_W;
  localparam int SIZE_BITS = sqmm_pkg::SIZE_W;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sqmm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sqmm_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [SIZE_BITS-1:0] cfg_wr_data = '0;

  square_matrix_multiply dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Matrix contents and size as the block should hold them
  logic signed [VAL_BITS-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [VAL_BITS-1:0] mat_b [MAX_DIM*MAX_DIM];
  logic [SIZE_BITS-1:0] size_setting = sqmm_pkg::SIZE_RESET;
  sqmm_pkg::out_item_t expected_sums[$];

  // Stimulus side: operations waiting to be sent and which elements are loaded
  sqmm_pkg::in_item_t pending_ops[$];
  bit loaded_a [MAX_DIM*MAX_DIM];
  bit loaded_b [MAX_DIM*MAX_DIM];

  int ops_queued = 0;
  int ops_accepted = 0;
  int ops_planned = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int flat_index(input logic [IDX_BITS-1:0] r,
                                    input logic [IDX_BITS-1:0] c);
    return r * MAX_DIM + c;
  endfunction

  function automatic logic signed [sqmm_pkg::SUM_W-1:0] dot_product(
      input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c);
    logic signed [sqmm_pkg::SUM_W-1:0] acc;
    logic signed [sqmm_pkg::SUM_W-1:0] prod;
    int span;
    span = (size_setting > MAX_DIM) ? MAX_DIM : int'(size_setting);
    acc = '0;
    for (int k = 0; k < span; k++) begin
      prod = mat_a[flat_index(r, IDX_BITS'(k))] * mat_b[flat_index(IDX_BITS'(k), c)];
      acc += prod;
    end
    return acc;
  endfunction

  task automatic predict_op(input sqmm_pkg::in_item_t op);
    sqmm_pkg::out_item_t res;
    case (op.kind)
      sqmm_pkg::KIND_WR_A: mat_a[flat_index(op.row, op.col)] = op.value;
      sqmm_pkg::KIND_WR_B: mat_b[flat_index(op.row, op.col)] = op.value;
      sqmm_pkg::KIND_QUERY: begin
        res.row_res = op.row;
        res.col_res = op.col;
        res.product_sum = dot_product(op.row, op.col);
        expected_sums.push_back(res);
      end
      default: ;
    endcase
  endtask

  function automatic logic signed [VAL_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return VAL_BITS'($urandom);
    endcase
  endfunction

  task automatic push_op(input logic [1:0] kind, input logic [IDX_BITS-1:0] r,
                         input logic [IDX_BITS-1:0] c,
                         input logic signed [VAL_BITS-1:0] v);
    sqmm_pkg::in_item_t op;
    op.kind = kind;
    op.row = r;
    op.col = c;
    op.value = v;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  task automatic push_load(input logic [1:0] kind, input logic [IDX_BITS-1:0] r,
                           input logic [IDX_BITS-1:0] c,
                           input logic signed [VAL_BITS-1:0] v);
    push_op(kind, r, c, v);
    if (kind == sqmm_pkg::KIND_WR_A) loaded_a[flat_index(r, c)] = 1'b1;
    else loaded_b[flat_index(r, c)] = 1'b1;
    ops_planned++;
  endtask

  // Load whatever the query would read that was never loaded, then ask for it
  task automatic push_query(input logic [IDX_BITS-1:0] r, input logic [IDX_BITS-1:0] c,
                            input int span);
    for (int k = 0; k < span; k++) begin
      if (!loaded_a[flat_index(r, IDX_BITS'(k))])
        push_load(sqmm_pkg::KIND_WR_A, r, IDX_BITS'(k), pick_value());
      if (!loaded_b[flat_index(IDX_BITS'(k), c)])
        push_load(sqmm_pkg::KIND_WR_B, IDX_BITS'(k), c, pick_value());
    end
    push_op(sqmm_pkg::KIND_QUERY, r, c, VAL_BITS'($urandom));
    ops_planned++;
  endtask

  task automatic queue_mixed_ops(input int target, input int span);
    int choice;
    logic [IDX_BITS-1:0] r;
    logic [IDX_BITS-1:0] c;
    logic signed [VAL_BITS-1:0] fill;
    bit uniform;
    while (ops_planned < target) begin
      choice = $urandom_range(0, 99);
      r = IDX_BITS'($urandom_range(0, 15));
      c = IDX_BITS'($urandom_range(0, 15));
      if (choice < 55) begin
        push_query(r, c, span);
      end else if (choice < 80) begin
        push_load($urandom_range(0, 1) ? sqmm_pkg::KIND_WR_B : sqmm_pkg::KIND_WR_A,
                  r, c, pick_value());
      end else if (choice < 93) begin
        // reload a row of A and a column of B up to span, often with one value, then query
        fill = pick_value();
        uniform = ($urandom_range(0, 1) != 0);
        for (int k = 0; k < span; k++) begin
          push_load(sqmm_pkg::KIND_WR_A, r, IDX_BITS'(k), uniform ? fill : pick_value());
          push_load(sqmm_pkg::KIND_WR_B, IDX_BITS'(k), c, uniform ? fill : pick_value());
        end
        push_query(r, c, span);
      end else begin
        push_op(KIND_UNUSED, r, c, VAL_BITS'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (ops_accepted != ops_queued || expected_sums.size() != 0) @(posedge clk);
    // loads give no result, so let the last one settle
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_BITS-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    size_setting <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: hold the transfer until accepted, then advance or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_op(in_data);
        ops_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result(input sqmm_pkg::out_item_t got);
    sqmm_pkg::out_item_t want;
    if (expected_sums.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: row %0d col %0d sum %0d",
                 got.row_res, got.col_res, got.product_sum);
    end else begin
      want = expected_sums.pop_front();
      if (got.row_res !== want.row_res || got.col_res !== want.col_res ||
          got.product_sum !== want.product_sum) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected row %0d col %0d sum %0d, got row %0d col %0d sum %0d",
                   want.row_res, want.col_res, want.product_sum,
                   got.row_res, got.col_res, got.product_sum);
      end
    end
  endtask

  // Monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [SIZE_BITS-1:0] phase_size [6];
    int span;
    phase_size = '{5'd16, 5'd31, 5'd1, 5'd16, 5'd17, 5'd16};
    phase_size[3] = SIZE_BITS'($urandom_range(2, 15));
    send_idle_pct <= 38;
    recv_idle_pct <= 52;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes at size one, unused kind, indexes beyond the size in use
    write_size(5'd1);
    push_load(sqmm_pkg::KIND_WR_A, 4'd0, 4'd0, 16'sh8000);
    push_load(sqmm_pkg::KIND_WR_B, 4'd0, 4'd0, 16'sh8000);
    push_query(4'd0, 4'd0, 1);
    push_load(sqmm_pkg::KIND_WR_A, 4'd0, 4'd0, 16'sh7fff);
    push_query(4'd0, 4'd0, 1);
    push_load(sqmm_pkg::KIND_WR_B, 4'd0, 4'd0, 16'sh7fff);
    push_op(KIND_UNUSED, 4'd0, 4'd0, -16'sd1);
    push_query(4'd0, 4'd0, 1);
    push_load(sqmm_pkg::KIND_WR_A, 4'd15, 4'd0, -16'sd1);
    push_load(sqmm_pkg::KIND_WR_B, 4'd0, 4'd15, 16'sh8000);
    push_load(sqmm_pkg::KIND_WR_A, 4'd15, 4'd15, 16'sd1234);
    push_query(4'd15, 4'd15, 1);
    // empty sum
    write_size(5'd0);
    push_query(4'd7, 4'd9, 0);
    push_query(4'd15, 4'd0, 0);
    write_size(5'd2);
    push_query(4'd15, 4'd15, 2);

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct <= 52;
        recv_idle_pct <= 38;
      end else if (p == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      write_size(phase_size[p]);
      span = (phase_size[p] > MAX_DIM) ? MAX_DIM : int'(phase_size[p]);
      queue_mixed_ops(ops_planned + PHASE_OPS, span);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
